// ===== rtl/core/sync_length_frame_receiver_defines.svh =====
// Assertion macros shared by the frame receiver RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SYNC_LENGTH_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SLFR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slfr check failed");

// Next-cycle implication, disabled during reset.
`define SLFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slfr check failed");

`endif

// ===== rtl/core/slfr_pkg.sv =====
// Shared constants for the sync/length frame receiver.
// No dependencies; used by the top level.
package slfr_pkg;

  localparam int REG_COUNT            = 32;
  localparam int REG_AW               = 5;
  localparam int BUFFER_DEPTH_DEFAULT = 32;
  localparam int CFG_AW               = 3;
  localparam int CFG_DW               = 8;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_SYNC_FIRST    = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_SYNC_SECOND   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_STARTER_INDEX = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_ALIVE_INDEX   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_HORN_FOLLOWS  = 3'd4;

  // Configuration reset values
  localparam logic [7:0]        SYNC_FIRST_RST    = 8'd170;
  localparam logic [7:0]        SYNC_SECOND_RST   = 8'd85;
  localparam logic [REG_AW-1:0] STARTER_INDEX_RST = 5'd0;
  localparam logic [REG_AW-1:0] ALIVE_INDEX_RST   = 5'd1;

endpackage

// ===== rtl/core/slfr_if.sv =====
// Valid/ready channel interfaces for the frame receiver request and result beats.
// Depends on nothing but the port widths of the block.
interface slfr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic [4:0] read_index;

  modport source (output valid, req_type, rx_byte, read_index, input ready);
  modport sink (input valid, req_type, rx_byte, read_index, output ready);
endinterface

interface slfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       frame_done;
  logic       overflow;
  logic       starter_on;
  logic       horn_on;
  logic       link_alive;

  modport source (output valid, read_data, frame_done, overflow, starter_on, horn_on,
                  link_alive, input ready);
  modport sink (input valid, read_data, frame_done, overflow, starter_on, horn_on,
                link_alive, output ready);
endinterface

// ===== rtl/core/slfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/sync_length_frame_receiver.sv =====
// Frame receiver top level: byte parser, copy sequencer and committed register file.
// Depends on slfr_pkg, slfr_if.sv, slfr_ram and sync_length_frame_receiver_defines.svh.

// Each request beat yields one result beat. A read request passes through S_READ_CAP
// before S_PUT, and a byte that does not end a frame goes straight to S_PUT. A byte
// that ends a frame copies n = min(length, BUFFER_DEPTH, 32) entries, one a cycle from
// the receive buffer RAM read port into the register file RAM write port, and
// the starter and alive registers are then fetched one after the other through
// the register file's single read port. Register file entries carry valid bits
// cleared at reset, so no clearing pass is needed. The next request is taken as
// soon as the previous result is placed in the output register.
`include "sync_length_frame_receiver_defines.svh"

module sync_length_frame_receiver #(
  parameter int BUFFER_DEPTH = slfr_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  slfr_in_if.sink                       in_ch,
  slfr_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [slfr_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [slfr_pkg::CFG_DW-1:0]   cfg_data
);

  localparam int         BAW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);
  localparam logic [8:0] REGS9  = 9'(slfr_pkg::REG_COUNT);

  typedef enum logic [1:0] {PH_SYNC1, PH_SYNC2, PH_LEN, PH_DATA} phase_t;
  typedef enum logic [2:0] {
    S_IDLE, S_READ_CAP, S_COPY, S_ALIVE_RD, S_ALIVE_CAP, S_STARTER_CAP, S_PUT
  } state_t;

  state_t state;
  phase_t phase;

  logic [7:0]                    sync_first;
  logic [7:0]                    sync_second;
  logic [slfr_pkg::REG_AW-1:0]   starter_index;
  logic [slfr_pkg::REG_AW-1:0]   alive_index;
  logic                          horn_follows;

  logic [7:0] frame_length;
  logic [7:0] byte_count;
  logic       starter_level;
  logic       horn_level;
  logic       alive_level;

  logic [slfr_pkg::REG_COUNT-1:0] reg_valid;
  logic                           rd_ok;

  logic [5:0]                  copy_idx;
  logic [5:0]                  copy_n;
  logic                        copy_pend;
  logic [slfr_pkg::REG_AW-1:0] copy_waddr;

  logic [7:0] res_read_data;
  logic       res_done;
  logic       res_ovf;

  logic       out_valid;

  // memory ports
  logic                        buf_we;
  logic [BAW-1:0]              buf_waddr;
  logic [BAW-1:0]              buf_raddr;
  logic [7:0]                  buf_rdata;
  logic                        creg_we;
  logic [slfr_pkg::REG_AW-1:0] creg_raddr;
  logic [7:0]                  creg_rdata;

  logic       in_beat;
  logic       cnt_inc;
  logic [7:0] cnt_new;
  logic       complete;
  logic       frame_end;
  logic       len_ovf;
  logic [8:0] n_lim;
  logic       creg_hit;

  assign in_ch.ready = (state == S_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;

  always_comb begin
    cnt_inc   = byte_count < frame_length;
    cnt_new   = cnt_inc ? byte_count + 8'd1 : byte_count;
    complete  = (cnt_new == frame_length);
    frame_end = !in_ch.req_type && (phase == PH_DATA) && complete;
    len_ovf   = {1'b0, frame_length} > DEPTH9;
    n_lim     = {1'b0, frame_length};
    if (n_lim > DEPTH9) begin
      n_lim = DEPTH9;
    end
    if (n_lim > REGS9) begin
      n_lim = REGS9;
    end
  end

  always_comb begin
    buf_we    = in_beat && !in_ch.req_type && (phase == PH_DATA) && cnt_inc &&
                ({1'b0, byte_count} < DEPTH9);
    buf_waddr = BAW'(byte_count);
    buf_raddr = BAW'(copy_idx);
    creg_we   = (state == S_COPY) && copy_pend;
    case (state)
      S_ALIVE_RD:  creg_raddr = alive_index;
      S_ALIVE_CAP: creg_raddr = starter_index;
      default:     creg_raddr = in_ch.read_index;
    endcase
  end

  // never-written register file entries read as zero
  assign creg_hit = rd_ok && (creg_rdata == 8'd1);

  slfr_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_rx_buf (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (buf_waddr),
    .wr_data (in_ch.rx_byte),
    .rd_addr (buf_raddr),
    .rd_data (buf_rdata)
  );

  slfr_ram #(.WIDTH(8), .DEPTH(slfr_pkg::REG_COUNT)) u_creg (
    .clk     (clk),
    .wr_en   (creg_we),
    .wr_addr (copy_waddr),
    .wr_data (buf_rdata),
    .rd_addr (creg_raddr),
    .rd_data (creg_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_SYNC1;
      sync_first    <= slfr_pkg::SYNC_FIRST_RST;
      sync_second   <= slfr_pkg::SYNC_SECOND_RST;
      starter_index <= slfr_pkg::STARTER_INDEX_RST;
      alive_index   <= slfr_pkg::ALIVE_INDEX_RST;
      horn_follows  <= 1'b0;
      frame_length  <= '0;
      byte_count    <= '0;
      starter_level <= 1'b0;
      horn_level    <= 1'b0;
      alive_level   <= 1'b0;
      reg_valid     <= '0;
      rd_ok         <= 1'b0;
      copy_idx      <= '0;
      copy_n        <= '0;
      copy_pend     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          slfr_pkg::CFG_SYNC_FIRST:    sync_first    <= cfg_data;
          slfr_pkg::CFG_SYNC_SECOND:   sync_second   <= cfg_data;
          slfr_pkg::CFG_STARTER_INDEX: starter_index <= cfg_data[slfr_pkg::REG_AW-1:0];
          slfr_pkg::CFG_ALIVE_INDEX:   alive_index   <= cfg_data[slfr_pkg::REG_AW-1:0];
          slfr_pkg::CFG_HORN_FOLLOWS:  horn_follows  <= cfg_data[0];
          default: ;
        endcase
      end

      if (creg_we) begin
        reg_valid[copy_waddr] <= 1'b1;
      end
      rd_ok <= reg_valid[creg_raddr];

      // S_PUT reloads the output register itself
      if (out_valid && out_ch.ready && (state != S_PUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            res_read_data <= '0;
            res_done      <= frame_end;
            res_ovf       <= frame_end && len_ovf;
            if (in_ch.req_type) begin
              state <= S_READ_CAP;
            end else begin
              state <= frame_end ? S_COPY : S_PUT;
              unique case (phase)
                PH_SYNC1: begin
                  if (in_ch.rx_byte == sync_first) begin
                    phase <= PH_SYNC2;
                  end
                end
                PH_SYNC2: begin
                  phase <= (in_ch.rx_byte == sync_second) ? PH_LEN : PH_SYNC1;
                end
                PH_LEN: begin
                  frame_length <= in_ch.rx_byte;
                  byte_count   <= '0;
                  phase        <= PH_DATA;
                end
                PH_DATA: begin
                  byte_count <= cnt_new;
                  if (complete) begin
                    phase     <= PH_SYNC1;
                    copy_n    <= 6'(n_lim);
                    copy_idx  <= '0;
                    copy_pend <= 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_READ_CAP: begin
          res_read_data <= rd_ok ? creg_rdata : 8'd0;
          state         <= S_PUT;
        end
        S_COPY: begin
          // read buffer entry i while writing entry i-1 fetched last cycle
          if (copy_idx < copy_n) begin
            copy_idx   <= copy_idx + 6'd1;
            copy_waddr <= slfr_pkg::REG_AW'(copy_idx);
            copy_pend  <= 1'b1;
          end else begin
            copy_pend <= 1'b0;
            state     <= S_ALIVE_RD;
          end
        end
        S_ALIVE_RD: begin
          state <= S_ALIVE_CAP;
        end
        S_ALIVE_CAP: begin
          alive_level <= creg_hit;
          state       <= S_STARTER_CAP;
        end
        S_STARTER_CAP: begin
          starter_level <= creg_hit && alive_level;
          if (horn_follows) begin
            horn_level <= creg_hit && alive_level;
          end
          state <= S_PUT;
        end
        S_PUT: begin
          if (!out_valid || out_ch.ready) begin
            out_ch.read_data  <= res_read_data;
            out_ch.frame_done <= res_done;
            out_ch.overflow   <= res_ovf;
            out_ch.starter_on <= starter_level;
            out_ch.horn_on    <= horn_level;
            out_ch.link_alive <= alive_level;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;

  `SLFR_ASSERT_NOW(a_busy_copy, clk, rst, state == S_COPY, !in_ch.ready)
  `SLFR_ASSERT_NOW(a_ovf_done, clk, rst, out_ch.valid && out_ch.overflow, out_ch.frame_done)
  `SLFR_ASSERT_NOW(a_copy_range, clk, rst, creg_we, {1'b0, copy_waddr} < copy_n)
  `SLFR_ASSERT_NEXT(a_read_path, clk, rst, in_beat && in_ch.req_type, state == S_READ_CAP)

endmodule
